// ===== rtl/ptw_pkg.sv =====
// Shared types and constants for the four-level page table walker.
// Used by ptw_ctrl, ptw_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ptw_pkg;

  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int FRAME_W           = 40;
  localparam int ENTRY_W           = 64;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int OFFSET_W          = 12;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

  // Level 4 (root) is walked first, level 1 (leaf table) last.
  localparam logic [1:0] LVL_ROOT = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_LEAF = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;           // capture the request word
    logic       rd;             // read entry {page, index of lvl}
    logic       follow;         // page <= pool page named by the read entry
    logic       wr_link;        // link a fresh table, take it from the pool
    logic       wr_leaf;        // write the leaf entry
    logic       clr_page_init;  // point the clear sweep at the next free page
    logic       clr_step;       // zero one entry of the sweep and advance
    logic [1:0] lvl;
  } ptw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic present;    // read entry has its present bit set
    logic outside;    // read entry names a frame outside the pool
    logic pool_full;  // no free table page left
    logic clr_last;   // clear sweep is at its last entry
    logic query;      // captured request is a query
  } ptw_stat_t;

endpackage

// ===== rtl/ptw_datapath.sv =====
// Datapath of the page table walker: request registers, table store memory,
// pool allocator, entry decode and clear sweep. Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_datapath #(
  parameter int POOL_PAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ptw_pkg::ptw_cmd_t            cmd,
  output ptw_pkg::ptw_stat_t           stat,
  input  logic                         cfg_we,
  input  logic [ptw_pkg::FRAME_W-1:0]  cfg_data,
  input  logic                         mode,
  input  logic [ptw_pkg::VA_W-1:0]     vaddr,
  input  logic [ptw_pkg::PA_W-1:0]     paddr,
  input  logic [ptw_pkg::ENTRY_W-1:0]  leaf_flags
);

  localparam int PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int NW    = $clog2(POOL_PAGES + 1);
  localparam int AW    = PW + ptw_pkg::IDX_W;
  localparam int DEPTH = POOL_PAGES * ptw_pkg::ENTRIES_PER_TABLE;

  logic [ptw_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [ptw_pkg::ENTRY_W-1:0] rdata;

  logic [ptw_pkg::FRAME_W-1:0] pool_base;
  logic [NW-1:0]               next_free;
  logic [AW-1:0]               clr_addr;
  logic                        clr_full;

  logic                        req_query;
  logic [ptw_pkg::VA_W-1:0]    req_va;
  logic [ptw_pkg::PA_W-1:0]    req_pa;
  logic [ptw_pkg::ENTRY_W-1:0] req_flags;
  logic [PW-1:0]               page;

  logic [ptw_pkg::IDX_W-1:0]   idx;
  logic [AW-1:0]               walk_addr;
  logic [ptw_pkg::FRAME_W-1:0] rel;
  logic [ptw_pkg::FRAME_W-1:0] link_frame;
  logic [ptw_pkg::ENTRY_W-1:0] link_entry;
  logic [ptw_pkg::ENTRY_W-1:0] leaf_entry;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [ptw_pkg::ENTRY_W-1:0] wdata;

  always_comb begin
    case (cmd.lvl)
      ptw_pkg::LVL_ROOT: idx = req_va[47:39];
      ptw_pkg::LVL_PDPT: idx = req_va[38:30];
      ptw_pkg::LVL_PD:   idx = req_va[29:21];
      default:           idx = req_va[20:12];
    endcase
  end

  assign walk_addr  = {page, idx};
  assign rel        = rdata[51:12] - pool_base;
  assign link_frame = pool_base + ptw_pkg::FRAME_W'(next_free);
  assign link_entry = {12'd0, link_frame, 9'd0, 3'b111};
  assign leaf_entry = {12'd0, req_pa[51:12], 12'd0} | req_flags
                      | ptw_pkg::ENTRY_W'(1);

  always_comb begin
    we    = 1'b0;
    waddr = walk_addr;
    wdata = '0;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (cmd.wr_link) begin
      we    = 1'b1;
      wdata = link_entry;
    end else if (cmd.wr_leaf) begin
      we    = 1'b1;
      wdata = leaf_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[walk_addr];
    end
  end

  assign stat.present   = rdata[0];
  assign stat.outside   = (rel >= ptw_pkg::FRAME_W'(POOL_PAGES));
  assign stat.pool_full = (next_free == NW'(POOL_PAGES));
  assign stat.clr_last  = clr_full ? (clr_addr == AW'(DEPTH - 1))
                                   : (&clr_addr[ptw_pkg::IDX_W-1:0]);
  assign stat.query     = req_query;

  // Control state: allocator, clear sweep and the base register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      next_free <= NW'(1);
      clr_addr  <= '0;
      clr_full  <= 1'b1;
    end else begin
      if (cfg_we) begin
        pool_base <= cfg_data;
      end
      if (cmd.wr_link) begin
        next_free <= next_free + NW'(1);
      end
      if (cmd.clr_page_init) begin
        clr_addr <= {next_free[PW-1:0], {ptw_pkg::IDX_W{1'b0}}};
        clr_full <= 1'b0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Request word and current table page.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_query <= mode;
      req_va    <= vaddr;
      req_pa    <= paddr;
      req_flags <= leaf_flags;
      page      <= '0;
    end else if (cmd.wr_link) begin
      page <= next_free[PW-1:0];
    end else if (cmd.follow) begin
      page <= rel[PW-1:0];
    end
  end

endmodule

// ===== rtl/ptw_ctrl.sv =====
// Controller state machine of the page table walker: sequences the clear
// sweeps, the level walk and the result strobe. Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output logic                is_present,
  output logic [1:0]          status,
  output ptw_pkg::ptw_cmd_t   cmd,
  input  ptw_pkg::ptw_stat_t  stat
);

  localparam logic [2:0] S_CLR_ALL  = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_READ     = 3'd2;
  localparam logic [2:0] S_CHECK    = 3'd3;
  localparam logic [2:0] S_CLR_PAGE = 3'd4;
  localparam logic [2:0] S_LINK     = 3'd5;
  localparam logic [2:0] S_LEAF     = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] lvl, lvl_next;
  logic       res_set;
  logic       res_present;
  logic [1:0] res_status;

  always_comb begin
    state_next  = state;
    lvl_next    = lvl;
    cmd         = '0;
    cmd.lvl     = lvl;
    res_set     = 1'b0;
    res_present = 1'b0;
    res_status  = ptw_pkg::STATUS_OK;
    case (state)
      S_CLR_ALL: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          lvl_next   = ptw_pkg::LVL_ROOT;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (lvl == ptw_pkg::LVL_LEAF) begin
          // Only a query reads the leaf level.
          res_set     = 1'b1;
          res_present = stat.present;
          state_next  = S_IDLE;
        end else if (!stat.present) begin
          if (stat.query) begin
            res_set    = 1'b1;
            state_next = S_IDLE;
          end else if (stat.pool_full) begin
            res_set    = 1'b1;
            res_status = ptw_pkg::STATUS_EXHAUSTED;
            state_next = S_IDLE;
          end else begin
            cmd.clr_page_init = 1'b1;
            state_next        = S_CLR_PAGE;
          end
        end else if (stat.outside) begin
          res_set    = 1'b1;
          res_status = ptw_pkg::STATUS_OUTSIDE;
          state_next = S_IDLE;
        end else begin
          cmd.follow = 1'b1;
          lvl_next   = lvl + 2'd1;
          if (lvl == ptw_pkg::LVL_PD && !stat.query) begin
            state_next = S_LEAF;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_CLR_PAGE: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_LINK;
      end
      S_LINK: begin
        cmd.wr_link = 1'b1;
        lvl_next    = lvl + 2'd1;
        if (lvl == ptw_pkg::LVL_PD) begin
          state_next = S_LEAF;
        end else begin
          state_next = S_READ;
        end
      end
      S_LEAF: begin
        cmd.wr_leaf = 1'b1;
        res_set     = 1'b1;
        res_present = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_ALL;
      lvl   <= ptw_pkg::LVL_ROOT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      done  <= res_set;
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      is_present <= res_present;
      status     <= res_status;
    end
  end

endmodule

// ===== rtl/four_level_page_table_walker.sv =====
// Top level of the four-level page table walker.
// Instantiates ptw_ctrl and ptw_datapath; depends on ptw_pkg.
`timescale 1ns / 1ps

// Usage:
// A request word (mode, vaddr, paddr, leaf_flags) is taken at a
// rising edge where start is high and busy is low. Mode 0 maps a page and
// mode 1 queries whether the address is mapped through all four levels.
// Exactly one result word follows per request: done is high for a single
// cycle with is_present and status valid in that cycle. The receiver cannot
// stall, so the result must be captured when done is seen.
// The pool base frame is written over the cfg_valid/cfg_ready channel;
// cfg_ready is always high, and writes belong only to idle periods.
// Each level is walked in two states: S_READ (registered memory read),
// then S_CHECK (decode). A query reads all four levels; a map reads the
// upper three and writes the leaf entry. Each newly allocated table adds
// a sweep that zeroes the page, plus a state that writes the link.
// The table store has a write port and a read port; the controller uses
// at most one of them at a time. A new word can be taken in the cycle
// where done is high.
// Reset: busy stays high while the whole table store is zeroed; the
// allocator restarts at pool page one and the base register returns to
// zero.

module four_level_page_table_walker #(
  parameter int POOL_PAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [ptw_pkg::VA_W-1:0]     vaddr,
  input  logic [ptw_pkg::PA_W-1:0]     paddr,
  input  logic [ptw_pkg::ENTRY_W-1:0]  leaf_flags,
  output logic                         done,
  output logic                         is_present,
  output logic [1:0]                   status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ptw_pkg::FRAME_W-1:0]  cfg_data
);

  ptw_pkg::ptw_cmd_t  cmd;
  ptw_pkg::ptw_stat_t stat;

  // The base register can always take a write.
  assign cfg_ready = 1'b1;

  ptw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .is_present (is_present),
    .status     (status),
    .cmd        (cmd),
    .stat       (stat)
  );

  ptw_datapath #(
    .POOL_PAGES (POOL_PAGES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .vaddr      (vaddr),
    .paddr      (paddr),
    .leaf_flags (leaf_flags)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the four-level page table walker.
// Depends on ptw_pkg and four_level_page_table_walker; reads no files.
`timescale 1ns / 1ps

module tb;

  localparam int POOL_PAGES   = 16;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_WORDS  = 192;

  localparam logic MODE_MAP   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Present, writable and user: the low bits of every table link.
  localparam logic [ptw_pkg::OFFSET_W-1:0] LINK_BITS = 12'h007;

  localparam logic [ptw_pkg::VA_W-1:0]    VA_MAX    = '1;
  localparam logic [ptw_pkg::PA_W-1:0]    PA_MAX    = '1;
  localparam logic [ptw_pkg::ENTRY_W-1:0] FLAGS_MAX = '1;
  localparam logic [ptw_pkg::FRAME_W-1:0] FRAME_MAX = '1;

  typedef enum logic {ROW_WORD, ROW_BASE} row_kind_t;

  // One row of the directed sequence: either a request word or a new base
  // frame. Rows with known_result set carry the result typed in by hand.
  typedef struct {
    row_kind_t                    kind;
    logic                         mode;
    logic [ptw_pkg::VA_W-1:0]     va;
    logic [ptw_pkg::PA_W-1:0]     pa;
    logic [ptw_pkg::ENTRY_W-1:0]  flags;
    logic [ptw_pkg::FRAME_W-1:0]  base;
    bit                           known_result;
    logic                         present;
    logic [1:0]                   status;
  } dir_row_t;

  typedef struct {
    logic                      mode;
    logic [ptw_pkg::VA_W-1:0]  va;
    logic                      present;
    logic [1:0]                status;
  } walk_result_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic                          mode;
  logic [ptw_pkg::VA_W-1:0]      vaddr;
  logic [ptw_pkg::PA_W-1:0]      paddr;
  logic [ptw_pkg::ENTRY_W-1:0]   leaf_flags;
  logic                          done;
  logic                          is_present;
  logic [1:0]                    status;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ptw_pkg::FRAME_W-1:0]   cfg_data;

  four_level_page_table_walker #(
    .POOL_PAGES (POOL_PAGES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .vaddr      (vaddr),
    .paddr      (paddr),
    .leaf_flags (leaf_flags),
    .done       (done),
    .is_present (is_present),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the table store, the page allocator and the base
  // register, updated where the DUT takes a word or a base write.
  logic [ptw_pkg::ENTRY_W-1:0]  model_tables [POOL_PAGES*ptw_pkg::ENTRIES_PER_TABLE];
  int unsigned                  model_next_page;
  logic [ptw_pkg::FRAME_W-1:0]  model_base;

  walk_result_t                 pending_walks[$];
  logic [ptw_pkg::VA_W-1:0]     mapped_vas[$];
  dir_row_t                     dir_rows[$];

  // A hand-typed result for the word currently on the ports, if any.
  bit                  typed_on;
  logic                typed_present;
  logic [1:0]          typed_status;

  int                  cycles;
  int                  error_count;
  int                  n_maps;
  int                  n_queries;
  int                  n_present;
  int                  n_exhausted;
  int                  n_outside;
  int                  n_base_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Walks the shadow tables for one word, applying its side effects, and
  // returns the result the walker must give. The walk goes root first;
  // a map allocates each missing intermediate table in pool order.
  function automatic void predict_walk(input logic qry,
                                       input logic [ptw_pkg::VA_W-1:0] va,
                                       input logic [ptw_pkg::PA_W-1:0] pa,
                                       input logic [ptw_pkg::ENTRY_W-1:0] flags,
                                       output logic present, output logic [1:0] st);
    int unsigned                  pg;
    int unsigned                  np;
    logic [ptw_pkg::IDX_W-1:0]    ix [4];
    logic [ptw_pkg::ENTRY_W-1:0]  ent;
    logic [ptw_pkg::FRAME_W-1:0]  rel;
    logic [ptw_pkg::FRAME_W-1:0]  link_frame;
    present = 1'b0;
    st      = ptw_pkg::STATUS_OK;
    pg      = 0;
    ix[0]   = va[47:39];
    ix[1]   = va[38:30];
    ix[2]   = va[29:21];
    ix[3]   = va[20:12];
    for (int lv = 0; lv < 3; lv++) begin
      ent = model_tables[pg*ptw_pkg::ENTRIES_PER_TABLE + ix[lv]];
      if (!ent[0]) begin
        // A query stops quietly at the first missing level.
        if (qry) return;
        if (model_next_page >= POOL_PAGES) begin
          st = ptw_pkg::STATUS_EXHAUSTED;
          return;
        end
        np = model_next_page;
        model_next_page++;
        for (int j = 0; j < ptw_pkg::ENTRIES_PER_TABLE; j++)
          model_tables[np*ptw_pkg::ENTRIES_PER_TABLE + j] = '0;
        link_frame = model_base + ptw_pkg::FRAME_W'(np);
        model_tables[pg*ptw_pkg::ENTRIES_PER_TABLE + ix[lv]] =
            {12'h000, link_frame, LINK_BITS};
        pg = np;
      end else begin
        // The named frame is taken relative to the current base, modulo
        // 2^40, so a moved base may send the walk anywhere or outside.
        rel = ent[51:12] - model_base;
        if (rel >= ptw_pkg::FRAME_W'(POOL_PAGES)) begin
          st = ptw_pkg::STATUS_OUTSIDE;
          return;
        end
        pg = int'(rel);
      end
    end
    if (qry) begin
      present = model_tables[pg*ptw_pkg::ENTRIES_PER_TABLE + ix[3]][0];
    end else begin
      model_tables[pg*ptw_pkg::ENTRIES_PER_TABLE + ix[3]] =
          {12'h000, pa[51:12], 12'h000} | flags | ptw_pkg::ENTRY_W'(1);
      present = 1'b1;
    end
  endfunction

  // Everything on the DUT's outputs is sampled here, at the rising edge.
  // Inputs only move at the falling edge, so the values read are stable.
  always @(posedge clk) begin
    logic          p;
    logic [1:0]    s;
    walk_result_t  w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("four_level_page_table_walker regression: fail");
      $finish;
    end
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_walks.size() == 0) begin
          flag_error($sformatf("result word with nothing pending: present %0d status %0d",
                               is_present, status));
        end else begin
          w = pending_walks.pop_front();
          if (is_present !== w.present || status !== w.status)
            flag_error($sformatf({"va %h mode %0d: expected present %0d status %0d, ",
                                  "got present %0d status %0d"},
                                 w.va, w.mode, w.present, w.status, is_present, status));
          if (is_present === 1'b1) n_present++;
          if (status === ptw_pkg::STATUS_EXHAUSTED) n_exhausted++;
          if (status === ptw_pkg::STATUS_OUTSIDE) n_outside++;
        end
      end
      if (start && busy === 1'b0) begin
        predict_walk(mode, vaddr, paddr, leaf_flags, p, s);
        if (mode == MODE_MAP && p && mapped_vas.size() < 64) mapped_vas.push_back(vaddr);
        if (mode == MODE_MAP) n_maps++;
        else n_queries++;
        w.mode    = mode;
        w.va      = vaddr;
        w.present = typed_on ? typed_present : p;
        w.status  = typed_on ? typed_status : s;
        pending_walks.push_back(w);
      end
      if (cfg_valid && cfg_ready) begin
        model_base = cfg_data;
        n_base_writes++;
      end
    end
  end

  // Presents one request word and returns at the edge that takes it.
  // Before the word the sender may idle; start stays high between words
  // that follow back to back.
  task automatic issue_word(input logic m, input logic [ptw_pkg::VA_W-1:0] va,
                            input logic [ptw_pkg::PA_W-1:0] pa,
                            input logic [ptw_pkg::ENTRY_W-1:0] fl,
                            input bit known, input logic kp, input logic [1:0] ks,
                            input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start      = 1'b0;
      mode       = 1'($urandom);
      vaddr      = ptw_pkg::VA_W'({$urandom, $urandom});
      paddr      = ptw_pkg::PA_W'({$urandom, $urandom});
      leaf_flags = {$urandom, $urandom};
    end
    @(negedge clk);
    start         = 1'b1;
    mode          = m;
    vaddr         = va;
    paddr         = pa;
    leaf_flags    = fl;
    typed_on      = known;
    typed_present = kp;
    typed_status  = ks;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drops start and waits until the walker is idle with nothing pending.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_walks.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [ptw_pkg::FRAME_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic dir_row_t word_row(input logic m, input logic [ptw_pkg::VA_W-1:0] va,
                                        input logic [ptw_pkg::PA_W-1:0] pa,
                                        input logic [ptw_pkg::ENTRY_W-1:0] fl,
                                        input bit known,
                                        input logic kp, input logic [1:0] ks);
    dir_row_t r;
    r.kind         = ROW_WORD;
    r.mode         = m;
    r.va           = va;
    r.pa           = pa;
    r.flags        = fl;
    r.base         = '0;
    r.known_result = known;
    r.present      = kp;
    r.status       = ks;
    return r;
  endfunction

  function automatic dir_row_t base_row(input logic [ptw_pkg::FRAME_W-1:0] v);
    dir_row_t r;
    r      = word_row(MODE_QUERY, '0, '0, '0, 1'b0, 1'b0, ptw_pkg::STATUS_OK);
    r.kind = ROW_BASE;
    r.base = v;
    return r;
  endfunction

  initial begin
    logic [ptw_pkg::FRAME_W-1:0]  phase_base [6];
    logic [ptw_pkg::VA_W-1:0]     va;
    logic [ptw_pkg::PA_W-1:0]     pa;
    logic [ptw_pkg::ENTRY_W-1:0]  fl;
    int                           r;
    int                           idle_pct;

    rst        = 1'b1;
    start      = 1'b0;
    mode       = MODE_MAP;
    vaddr      = '0;
    paddr      = '0;
    leaf_flags = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    typed_on   = 1'b0;
    typed_present = 1'b0;
    typed_status  = ptw_pkg::STATUS_OK;
    cycles        = 0;
    error_count   = 0;
    n_maps        = 0;
    n_queries     = 0;
    n_present     = 0;
    n_exhausted   = 0;
    n_outside     = 0;
    n_base_writes = 0;
    foreach (model_tables[i]) model_tables[i] = '0;
    model_next_page = 1;
    model_base      = '0;

    // Directed part. The base sits at its top value, so the link written
    // for page k wraps to frame k-1. The first two maps build two full
    // paths; further maps use up the rest of the fifteen free pages until
    // the pool runs dry part way through a walk. The base is then moved so
    // that old links land on other pages, and moved again so that they
    // point outside the pool altogether.
    dir_rows.push_back(base_row(FRAME_MAX));
    dir_rows.push_back(word_row(MODE_QUERY, '0, '0, '0, 1'b1, 1'b0, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_QUERY, VA_MAX, '0, '0, 1'b1, 1'b0, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_MAP, '0, '0, '0, 1'b1, 1'b1, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_QUERY, '0, '0, '0, 1'b1, 1'b1, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_MAP, VA_MAX, PA_MAX, FLAGS_MAX, 1'b1, 1'b1,
                                ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_QUERY, VA_MAX, '0, '0, 1'b1, 1'b1, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_QUERY, 48'h0000_0000_1000, '0, '0, 1'b1, 1'b0,
                                ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_MAP, 48'h0000_0000_1FFF, 52'h0_0123_4567_8ABC,
                                64'h8000_0000_0000_0006, 1'b1, 1'b1, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_QUERY, 48'h0000_0000_1ABC, '0, '0, 1'b1, 1'b1,
                                ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_MAP, 48'h0000_0020_0000, 52'h0_00AB_CDEF_0000, '0,
                                1'b1, 1'b1, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_QUERY, 48'h0000_4000_0000, '0, '0, 1'b1, 1'b0,
                                ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_MAP, 48'h0080_0000_0000, 52'h0_0000_0000_7000, '0,
                                1'b1, 1'b1, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_MAP, 48'h0100_0000_0000, 52'h0_0000_0000_8000, '0,
                                1'b1, 1'b1, ptw_pkg::STATUS_OK));
    // Two pages left but three needed: the pool runs out at the leaf table.
    dir_rows.push_back(word_row(MODE_MAP, 48'h0180_0000_0000, 52'h0_0000_0000_9000, '0,
                                1'b1, 1'b0, ptw_pkg::STATUS_EXHAUSTED));
    dir_rows.push_back(word_row(MODE_QUERY, 48'h0180_0000_0000, '0, '0, 1'b1, 1'b0,
                                ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_MAP, 48'h0180_0000_0000, 52'h0_0000_0000_9000, '0,
                                1'b1, 1'b0, ptw_pkg::STATUS_EXHAUSTED));
    dir_rows.push_back(word_row(MODE_MAP, 48'h0080_0000_5000, 52'h0_0000_0000_A000,
                                64'h0000_0000_0000_0002, 1'b1, 1'b1, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_QUERY, 48'h0080_0000_5123, '0, '0, 1'b1, 1'b1,
                                ptw_pkg::STATUS_OK));
    dir_rows.push_back(base_row('0));
    dir_rows.push_back(word_row(MODE_QUERY, '0, '0, '0, 1'b0, 1'b0, ptw_pkg::STATUS_OK));
    dir_rows.push_back(word_row(MODE_QUERY, VA_MAX, '0, '0, 1'b0, 1'b0, ptw_pkg::STATUS_OK));
    dir_rows.push_back(base_row(40'h00_0000_1000));
    dir_rows.push_back(word_row(MODE_QUERY, '0, '0, '0, 1'b1, 1'b0,
                                ptw_pkg::STATUS_OUTSIDE));
    dir_rows.push_back(word_row(MODE_MAP, VA_MAX, PA_MAX, '0, 1'b1, 1'b0,
                                ptw_pkg::STATUS_OUTSIDE));

    // Reset is asserted first and then released; the walker then clears the
    // whole store, which write_base waits out through busy.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_BASE)
        write_base(dir_rows[i].base);
      else
        issue_word(dir_rows[i].mode, dir_rows[i].va, dir_rows[i].pa, dir_rows[i].flags,
                   dir_rows[i].known_result, dir_rows[i].present, dir_rows[i].status, 0);
    end

    // Random part, in six phases with their own base. Half the phases use the
    // base the tables were built under, so walks go all the way down; the
    // others shift it by two pages, zero it, or pick it at random.
    // The sender idles often in the first two phases, very often in the
    // next two, and never in the last two.
    phase_base[0] = FRAME_MAX;
    phase_base[1] = '0;
    phase_base[2] = FRAME_MAX;
    phase_base[3] = ptw_pkg::FRAME_W'({$urandom, $urandom});
    phase_base[4] = FRAME_MAX - 40'd2;
    phase_base[5] = FRAME_MAX;
    for (int ph = 0; ph < 6; ph++) begin
      write_base(phase_base[ph]);
      idle_pct = (ph < 2) ? 23 : (ph < 4) ? 78 : 0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // Most addresses reuse a mapped path, some with a fresh leaf,
        // directory or upper index; the rest are noise.
        r = $urandom_range(0, 99);
        if (mapped_vas.size() != 0 && r < 75) begin
          va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
          if (r >= 40 && r < 60) va[20:12] = 9'($urandom);
          else if (r >= 60 && r < 70) va[29:12] = 18'($urandom);
          else if (r >= 70) va[38:12] = 27'($urandom);
          va[11:0] = 12'($urandom);
        end else begin
          va = ptw_pkg::VA_W'({$urandom, $urandom});
        end
        // Half the physical addresses land on or just past the pool frames, so
        // that a leaf later read as a table link may still point inside the pool.
        if ($urandom_range(0, 1))
          pa = ptw_pkg::PA_W'({$urandom, $urandom});
        else
          pa = {model_base + ptw_pkg::FRAME_W'($urandom_range(0, 17)), 12'($urandom)};
        case ($urandom_range(0, 2))
          0:       fl = {$urandom, $urandom};
          1:       fl = '0;
          default: fl = ptw_pkg::ENTRY_W'($urandom_range(0, 4095));
        endcase
        issue_word(1'($urandom), va, pa, fl, 1'b0, 1'b0, ptw_pkg::STATUS_OK, idle_pct);
      end
    end

    settle();
    if (pending_walks.size() != 0)
      flag_error($sformatf("%0d expected result words never arrived", pending_walks.size()));

    $display({"Covered %0d requests (%0d maps, %0d queries) over %0d base settings; ",
              "%0d pool pages handed out."},
             n_maps + n_queries, n_maps, n_queries, n_base_writes, model_next_page - 1);
    $display("Results: %0d present, %0d pool exhausted, %0d outside pool; %0d errors.",
             n_present, n_exhausted, n_outside, error_count);
    if (error_count == 0) begin
      $display("four_level_page_table_walker regression: pass");
    end else begin
      $display("four_level_page_table_walker regression: fail");
    end
    $finish;
  end

endmodule
